// ===== rtl/core/nts_pkg.sv =====
// package: types and character constants for the number text splitter
`timescale 1ns / 1ps
package nts_pkg;

  // parse phases
  typedef enum logic [2:0] {
    PH_LEAD,
    PH_INT,
    PH_FRAC,
    PH_EXPSIGN,
    PH_EXPDIG,
    PH_TRAIL,
    PH_UNITS,
    PH_DONE
  } phase_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_NUM   = 2'd0,
    KIND_UNITS = 2'd1,
    KIND_SUM   = 2'd2
  } kind_e;

  // configuration register indexes
  localparam logic CFG_EXP_MIN = 1'b0;
  localparam logic CFG_EXP_MAX = 1'b1;

  localparam logic signed [15:0] EXP_MIN_RST = -16'sd99;
  localparam logic signed [15:0] EXP_MAX_RST = 16'sd99;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;

  localparam int unsigned MAG_W = 17;
  localparam logic [MAG_W-1:0] MAG_CAP = '1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // one result item
  typedef struct packed {
    kind_e              kind;
    logic [7:0]         out_char;
    logic               number_ok;
    logic signed [15:0] exponent;
    logic               last_of_item;
  } result_t;

endpackage

// ===== rtl/core/nts_in_if.sv =====
// interface: input channel carrying one text byte or an end mark per item
`timescale 1ns / 1ps
interface nts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_end;

  modport source (output valid, output text_byte, output is_end, input ready);
  modport sink (input valid, input text_byte, input is_end, output ready);
endinterface

// ===== rtl/core/nts_out_if.sv =====
// interface: output channel carrying one result item
`timescale 1ns / 1ps
interface nts_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         out_char;
  logic               number_ok;
  logic signed [15:0] exponent;
  logic               last_of_item;

  modport source (output valid, output kind, output out_char, output number_ok,
                  output exponent, output last_of_item, input ready);
  modport sink (input valid, input kind, input out_char, input number_ok,
                input exponent, input last_of_item, output ready);
endinterface

// ===== rtl/core/number_text_splitter_top.sv =====
// top level: number text splitter, byte parser with a small result queue
`timescale 1ns / 1ps
// Parses a text, one byte per input item, into a number and a units word.
// Leading blanks are skipped, a '-' sign is passed on, digits are passed with
// commas dropped, a '.' is put before the first fraction digit, an exponent
// after 'e'/'E' is accumulated (saturating), and the word after trailing
// blanks comes out as units characters. An end item gives one summary result
// (number_ok and the range checked exponent) and restarts the parser. The
// parser takes one item per clock while in_i.ready is high: each accepted
// item updates the phase registers and pushes its zero, one or two results
// into a 4-entry result queue in the same edge. The output drains one result
// per cycle while out_o.ready is high, which sets the rate: items with at most
// one result flow at one per cycle, one making both the '.' and a digit fills
// two queue entries. The input is ready whenever the queue has room for two
// results. Configuration is taken through cfg_we_i / cfg_idx_i / cfg_data_i
// only while the block is idle, a user's rule that the block does not enforce.
module number_text_splitter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  nts_in_if.sink      in_i,
  nts_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import nts_pkg::*;

  // configuration registers
  logic signed [15:0] exp_min_q, exp_max_q;

  // parser state
  phase_e           phase_q, phase_d;
  logic             saw_q, saw_d;
  logic             pt_q, pt_d;
  logic             exp_pres_q, exp_pres_d;
  logic             exp_neg_q, exp_neg_d;
  logic [MAG_W-1:0] mag_q, mag_d;

  // result queue
  result_t           queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  logic       accept, pop;
  logic [1:0] n_res;
  result_t    res0, res1;

  logic [7:0]               c;
  logic                     stop;
  logic                     is_dig;
  logic [3:0]               dval;
  logic [MAG_W+3:0]         mag_next;
  logic signed [MAG_W:0]    exp_val;
  logic                     in_range;
  logic                     sum_ok;

  assign in_i.ready = (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));
  assign accept     = in_i.valid & in_i.ready;
  assign pop        = out_o.valid & out_o.ready;

  assign c      = in_i.text_byte;
  assign is_dig = (c inside {[CH_ZERO:CH_NINE]});
  assign dval   = 4'(c - CH_ZERO);
  // times ten plus digit as shift and add
  assign mag_next = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + {{(MAG_W){1'b0}}, dval};

  // summary: signed exponent and range check against the registers
  assign exp_val  = exp_neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
  assign in_range = (exp_val >= (MAG_W+1)'(exp_min_q)) && (exp_val <= (MAG_W+1)'(exp_max_q));
  assign sum_ok   = saw_q && (!exp_pres_q || in_range);

  // per item parse, phases fall through the way the text reads
  always_comb begin
    phase_d    = phase_q;
    saw_d      = saw_q;
    pt_d       = pt_q;
    exp_pres_d = exp_pres_q;
    exp_neg_d  = exp_neg_q;
    mag_d      = mag_q;
    n_res      = 2'd0;
    stop       = 1'b0;
    res0       = '{kind: KIND_NUM, out_char: 8'h00, number_ok: 1'b0,
                   exponent: 16'sd0, last_of_item: 1'b0};
    res1       = res0;

    if (in_i.is_end) begin
      res0.kind         = KIND_SUM;
      res0.number_ok    = sum_ok;
      res0.exponent     = (sum_ok && exp_pres_q) ? exp_val[15:0] : 16'sd0;
      n_res             = 2'd1;
      phase_d           = PH_LEAD;
      saw_d             = 1'b0;
      pt_d              = 1'b0;
      exp_pres_d        = 1'b0;
      exp_neg_d         = 1'b0;
      mag_d             = '0;
    end else begin
      if (phase_d == PH_LEAD) begin
        if (c == CH_NUL) begin
          phase_d = PH_DONE;
          stop    = 1'b1;
        end else if (c == CH_SPACE) begin
          stop = 1'b1;
        end else if (c == CH_PLUS) begin
          phase_d = PH_INT;
          stop    = 1'b1;
        end else if (c == CH_MINUS) begin
          res0.out_char = c;
          n_res         = 2'd1;
          phase_d       = PH_INT;
          stop          = 1'b1;
        end else begin
          phase_d = PH_INT;
        end
      end
      if (!stop && phase_d == PH_INT) begin
        if (c == CH_NUL) begin
          phase_d = PH_DONE;
          stop    = 1'b1;
        end else if (is_dig) begin
          res0.out_char = c;
          n_res         = 2'd1;
          saw_d         = 1'b1;
          stop          = 1'b1;
        end else if (c == CH_COMMA) begin
          // a comma counts as a digit seen but is dropped
          saw_d = 1'b1;
          stop  = 1'b1;
        end else begin
          phase_d = PH_FRAC;
          if (c == CH_POINT) stop = 1'b1;
        end
      end
      if (!stop && phase_d == PH_FRAC) begin
        if (c == CH_NUL) begin
          phase_d = PH_DONE;
          stop    = 1'b1;
        end else if (is_dig) begin
          if (!pt_q) begin
            res0.out_char = CH_POINT;
            res1.out_char = c;
            n_res         = 2'd2;
            pt_d          = 1'b1;
          end else begin
            res0.out_char = c;
            n_res         = 2'd1;
          end
          saw_d = 1'b1;
          stop  = 1'b1;
        end else if (!saw_d) begin
          phase_d = PH_DONE;
          stop    = 1'b1;
        end else if (c == CH_LOW_E || c == CH_UP_E) begin
          phase_d = PH_EXPSIGN;
          stop    = 1'b1;
        end else begin
          phase_d = PH_TRAIL;
        end
      end
      if (!stop && phase_d == PH_EXPSIGN) begin
        exp_pres_d = 1'b1;
        phase_d    = PH_EXPDIG;
        if (c == CH_PLUS) begin
          stop = 1'b1;
        end else if (c == CH_MINUS) begin
          exp_neg_d = 1'b1;
          stop      = 1'b1;
        end
      end
      if (!stop && phase_d == PH_EXPDIG) begin
        if (c == CH_NUL) begin
          phase_d = PH_DONE;
          stop    = 1'b1;
        end else if (is_dig) begin
          // saturate once the value leaves the magnitude width
          mag_d = (mag_next[MAG_W+3:MAG_W] != '0) ? MAG_CAP : mag_next[MAG_W-1:0];
          stop  = 1'b1;
        end else begin
          phase_d = PH_TRAIL;
        end
      end
      if (!stop && phase_d == PH_TRAIL) begin
        if (c == CH_NUL) begin
          phase_d = PH_DONE;
          stop    = 1'b1;
        end else if (c == CH_SPACE) begin
          stop = 1'b1;
        end else begin
          phase_d = PH_UNITS;
        end
      end
      if (!stop && phase_d == PH_UNITS) begin
        if (c == CH_NUL || c == CH_SPACE) begin
          phase_d = PH_DONE;
        end else begin
          res0.kind     = KIND_UNITS;
          res0.out_char = c;
          n_res         = 2'd1;
        end
      end
    end

    // mark the final result of this item
    if (n_res == 2'd1) res0.last_of_item = 1'b1;
    if (n_res == 2'd2) res1.last_of_item = 1'b1;
  end

  assign cnt_d = cnt_q + (accept ? QCNT_W'(n_res) : '0) - QCNT_W'(pop);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_min_q <= EXP_MIN_RST;
      exp_max_q <= EXP_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EXP_MIN: exp_min_q <= cfg_data_i;
        CFG_EXP_MAX: exp_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // parser state and queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LEAD;
      saw_q      <= 1'b0;
      pt_q       <= 1'b0;
      exp_pres_q <= 1'b0;
      exp_neg_q  <= 1'b0;
      mag_q      <= '0;
      wr_q       <= '0;
      rd_q       <= '0;
      cnt_q      <= '0;
    end else begin
      if (accept) begin
        phase_q    <= phase_d;
        saw_q      <= saw_d;
        pt_q       <= pt_d;
        exp_pres_q <= exp_pres_d;
        exp_neg_q  <= exp_neg_d;
        mag_q      <= mag_d;
        wr_q       <= wr_q + QPTR_W'(n_res);
      end
      if (pop) rd_q <= rd_q + QPTR_W'(1);
      cnt_q <= cnt_d;
    end
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    if (accept && n_res != 2'd0) queue_q[wr_q] <= res0;
    if (accept && n_res == 2'd2) queue_q[wr_q + QPTR_W'(1)] <= res1;
  end

  assign out_o.valid        = (cnt_q != '0);
  assign out_o.kind         = queue_q[rd_q].kind;
  assign out_o.out_char     = queue_q[rd_q].out_char;
  assign out_o.number_ok    = queue_q[rd_q].number_ok;
  assign out_o.exponent     = queue_q[rd_q].exponent;
  assign out_o.last_of_item = queue_q[rd_q].last_of_item;

endmodule
